/* hdl/ortt_pkg.sv */
// Shared types and constants of the retransmit tracker.
package ortt_pkg;

    localparam int unsigned DEFAULT_TABLE_DEPTH = 16;
    localparam logic [31:0] RESET_TIMEOUT = 32'd1000;
    localparam logic [7:0]  RESET_RETRY_LIMIT = 8'd3;
    localparam logic [31:0] FIRST_ID = 32'd1;

    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_RESP = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [2:0] KIND_TX      = 3'd0;
    localparam logic [2:0] KIND_RETX    = 3'd1;
    localparam logic [2:0] KIND_DONE_OK = 3'd2;
    localparam logic [2:0] KIND_NOMATCH = 3'd3;
    localparam logic [2:0] KIND_EXHAUST = 3'd4;
    localparam logic [2:0] KIND_FULL    = 3'd5;
    localparam logic [2:0] KIND_WALKEND = 3'd6;

    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_RETRY   = 1'b1;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] handle;
        logic [7:0]  retries;
        logic [31:0] sent_time;
    } entry_t;

    // per-cycle command from the controller to every cell
    typedef struct packed {
        logic shift;     // cells at or above the removal point take the neighbour's entry
        logic load_tail; // the entry at tail_pos takes ins_entry
    } cell_ctl_t;

endpackage

/* hdl/ortt_cell.sv */
// One slot of the age-ordered table: holds an entry, shifts down on removal.
module ortt_cell (
    input  logic              aclk,
    input  ortt_pkg::cell_ctl_t ctl,
    input  logic              in_range,   // slot is at or above removal point
    input  logic              is_tail,    // slot is the insertion point
    input  ortt_pkg::entry_t  upper_entry,
    input  ortt_pkg::entry_t  ins_entry,
    input  logic [31:0]       match_id,
    output ortt_pkg::entry_t  entry,
    output logic              id_hit
);
    import ortt_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb begin
        entry_next = entry_reg;
        if (ctl.shift && in_range) begin
            entry_next = upper_entry;
        end
        if (ctl.load_tail && is_tail) begin
            entry_next = ins_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry  = entry_reg;
    assign id_hit = (entry_reg.id == match_id);

endmodule

/* hdl/outstanding_request_retransmit_tracker.sv */
// Top level: controller and cell chain of the retransmit tracker.
// One item is in flight at a time: a new transfer is taken only once the previous item's last
// result has been taken by the receiver. For a response the id is compared in all cells at
// once, and the hit slot is reported while the cells above it shift down in the same cycle.
// A progress tick emits its results one by one: it inspects the head once the previous result
// has been taken, then rotates or removes it. A walk ends with a walk-end report, or with a
// retries-exhausted report after any retransmits. An unknown operation is dropped. Every
// output stall holds the flow until the result is taken.
module outstanding_request_retransmit_tracker #(
    parameter int unsigned TABLE_DEPTH = ortt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [31:0] s_handle,
    input  logic [31:0] s_response_id,
    input  logic [31:0] s_now_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [31:0] m_packet_id,
    output logic [31:0] m_owner_handle,
    output logic [7:0]  m_retry_count,
    output logic        m_last
);
    import ortt_pkg::*;

    localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_RESP  = 5'b00010,
        ST_HEAD  = 5'b00100,
        ST_ACT   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] timeout_reg;
    logic [7:0]  limit_reg;
    logic [31:0] next_id_reg, next_id_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] left_reg, left_next;
    logic [31:0] now_reg, now_next;
    logic [31:0] rid_reg, rid_next;
    logic        retire_reg, retire_next;   // head is to be removed (exhausted)

    logic        m_valid_reg, m_valid_next;
    logic [2:0]  kind_reg, kind_next;
    logic [31:0] pid_reg, pid_next;
    logic [31:0] oh_reg, oh_next;
    logic [7:0]  rc_reg, rc_next;
    logic        last_reg, last_next;

    cell_ctl_t   ctl;
    logic [IW-1:0] rm_pos;
    logic [IW-1:0] tail_pos;
    entry_t      ins_entry;
    entry_t      cell_q [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] hit_vec;
    logic [IW-1:0] first_pos;
    logic        any_hit;
    logic [31:0] age;
    entry_t      head;
    entry_t      rot_entry;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            entry_t up;
            if (g + 1 < TABLE_DEPTH) begin : g_up
                assign up = cell_q[g+1];
            end else begin : g_top
                assign up = cell_q[g];
            end
            ortt_cell u_cell (
                .aclk       (aclk),
                .ctl        (ctl),
                .in_range   (IW'(g) >= rm_pos),
                .is_tail    (IW'(g) == tail_pos),
                .upper_entry(up),
                .ins_entry  (ins_entry),
                .match_id   (rid_reg),
                .entry      (cell_q[g]),
                .id_hit     (hit_vec[g])
            );
        end
    endgenerate

    // lowest valid hit; a small priority chain over the valid prefix
    always_comb begin
        first_pos = '0;
        any_hit   = 1'b0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (hit_vec[i] && (CW'(i) < count_reg)) begin
                first_pos = IW'(i);
                any_hit   = 1'b1;
            end
        end
    end

    assign head = cell_q[0];
    assign age  = now_reg - head.sent_time;

    always_comb begin
        rot_entry           = head;
        rot_entry.retries   = head.retries + 8'd1;
        rot_entry.sent_time = now_reg;
    end

    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;

    always_comb begin
        state_next     = state_reg;
        next_id_next   = next_id_reg;
        count_next     = count_reg;
        left_next      = left_reg;
        now_next       = now_reg;
        rid_next       = rid_reg;
        retire_next    = retire_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        kind_next      = kind_reg;
        pid_next       = pid_reg;
        oh_next        = oh_reg;
        rc_next        = rc_reg;
        last_next      = last_reg;
        ctl            = '0;
        rm_pos         = '0;
        tail_pos       = count_reg[IW-1:0];
        ins_entry      = '{id: next_id_reg, handle: s_handle, retries: 8'd0,
                           sent_time: s_now_time};
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    now_next = s_now_time;
                    rid_next = s_response_id;
                    priority case (s_operation)
                        OP_SEND: begin
                            m_valid_next = 1'b1;
                            last_next    = 1'b1;
                            if (count_reg == CW'(TABLE_DEPTH)) begin
                                kind_next = KIND_FULL;
                                pid_next  = '0;
                                oh_next   = '0;
                                rc_next   = '0;
                            end else begin
                                ctl.load_tail = 1'b1;
                                kind_next     = KIND_TX;
                                pid_next      = next_id_reg;
                                oh_next       = s_handle;
                                rc_next       = '0;
                                next_id_next  = next_id_reg + 32'd1;
                                count_next    = count_reg + CW'(1);
                            end
                        end
                        OP_RESP: state_next = ST_RESP;
                        OP_TICK: begin
                            left_next  = count_reg;
                            state_next = ST_HEAD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RESP: begin
                m_valid_next = 1'b1;
                last_next    = 1'b1;
                if (any_hit) begin
                    kind_next = KIND_DONE_OK;
                    pid_next  = cell_q[first_pos].id;
                    oh_next   = cell_q[first_pos].handle;
                    rc_next   = cell_q[first_pos].retries;
                    ctl.shift = 1'b1;
                    rm_pos    = first_pos;
                    count_next = count_reg - CW'(1);
                end else begin
                    kind_next = KIND_NOMATCH;
                    pid_next  = '0;
                    oh_next   = '0;
                    rc_next   = '0;
                end
                state_next = ST_IDLE;
            end
            ST_HEAD: begin
                if (!m_valid_reg) begin
                    m_valid_next = 1'b1;
                    if (left_reg == '0 || age < timeout_reg) begin
                        kind_next  = KIND_WALKEND;
                        pid_next   = '0;
                        oh_next    = '0;
                        rc_next    = '0;
                        last_next  = 1'b1;
                        state_next = ST_IDLE;
                    end else if (head.retries >= limit_reg) begin
                        kind_next  = KIND_EXHAUST;
                        pid_next   = head.id;
                        oh_next    = head.handle;
                        rc_next    = head.retries;
                        last_next  = 1'b1;
                        retire_next = 1'b1;
                        state_next = ST_ACT;
                    end else begin
                        kind_next  = KIND_RETX;
                        pid_next   = head.id;
                        oh_next    = head.handle;
                        rc_next    = rot_entry.retries;
                        last_next  = 1'b0;
                        retire_next = 1'b0;
                        state_next = ST_ACT;
                    end
                end
            end
            ST_ACT: begin
                ctl.shift = 1'b1;
                rm_pos    = '0;
                if (retire_reg) begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_IDLE;
                end else begin
                    ctl.load_tail = 1'b1;
                    tail_pos      = IW'(count_reg - CW'(1));
                    ins_entry     = rot_entry;
                    left_next     = left_reg - CW'(1);
                    state_next    = ST_HEAD;
                end
            end
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            timeout_reg   <= RESET_TIMEOUT;
            limit_reg     <= RESET_RETRY_LIMIT;
            next_id_reg   <= FIRST_ID;
            count_reg     <= '0;
            left_reg      <= '0;
            m_valid_reg   <= 1'b0;
            retire_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            next_id_reg   <= next_id_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            m_valid_reg   <= m_valid_next;
            retire_reg    <= retire_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_TIMEOUT: timeout_reg <= cfg_data;
                    CFG_RETRY:   limit_reg   <= cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        now_reg     <= now_next;
        rid_reg     <= rid_next;
        kind_reg    <= kind_next;
        pid_reg     <= pid_next;
        oh_reg      <= oh_next;
        rc_reg      <= rc_next;
        last_reg    <= last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = kind_reg;
    assign m_packet_id    = pid_reg;
    assign m_owner_handle = oh_reg;
    assign m_retry_count  = rc_reg;
    assign m_last         = last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("table occupancy beyond depth");
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(kind_reg) && $stable(pid_reg))
        else $error("result changed while stalled");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !m_valid_reg)
        else $error("input accepted with result pending");
    a_walk_left: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ACT |-> left_reg != '0)
        else $error("walk acted with nothing left");

endmodule

/* bench/ortt_checker.sv */
// Checker for the retransmit tracker: predicts results from accepted transfers and compares.
`timescale 1ns / 1ps
module ortt_checker #(
    parameter int unsigned DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [31:0] s_handle,
    input  logic [31:0] s_response_id,
    input  logic [31:0] s_now_time,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_kind,
    input  logic [31:0] m_packet_id,
    input  logic [31:0] m_owner_handle,
    input  logic [7:0]  m_retry_count,
    input  logic        m_last,
    output int          fail_count,
    output int          pending
);
    import ortt_pkg::*;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] id;
        logic [31:0] handle;
        logic [7:0]  retries;
        logic        last;
    } tracker_result_t;

    tracker_result_t expected_results[$];
    entry_t          table_q[$];
    logic [31:0]     timeout_reg;
    logic [7:0]      retry_limit_reg;
    logic [31:0]     id_counter;

    assign pending = expected_results.size();

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s got %0h expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    function automatic tracker_result_t mk(input logic [2:0] k, input logic [31:0] i,
                                           input logic [31:0] h, input logic [7:0] r,
                                           input logic l);
        tracker_result_t x;
        x.kind = k; x.id = i; x.handle = h; x.retries = r; x.last = l;
        return x;
    endfunction

    task automatic predict_item(input logic [1:0] op, input logic [31:0] h,
                                input logic [31:0] rid, input logic [31:0] now);
        entry_t e;
        int left;
        bit hit;
        case (op)
            OP_SEND: begin
                if (table_q.size() >= DEPTH) begin
                    expected_results.push_back(mk(KIND_FULL, 32'd0, 32'd0, 8'd0, 1'b1));
                end else begin
                    e.id = id_counter; e.handle = h; e.retries = 8'd0; e.sent_time = now;
                    table_q.push_back(e);
                    expected_results.push_back(mk(KIND_TX, id_counter, h, 8'd0, 1'b1));
                    id_counter = id_counter + 32'd1;
                end
            end
            OP_RESP: begin
                hit = 0;
                for (int i = 0; i < table_q.size(); i++) begin
                    if (table_q[i].id == rid) begin
                        hit = 1;
                        expected_results.push_back(mk(KIND_DONE_OK, table_q[i].id,
                            table_q[i].handle, table_q[i].retries, 1'b1));
                        table_q.delete(i);
                        break;
                    end
                end
                if (!hit) expected_results.push_back(mk(KIND_NOMATCH, 32'd0, 32'd0, 8'd0, 1'b1));
            end
            OP_TICK: begin
                left = table_q.size();
                while (left > 0) begin
                    e = table_q[0];
                    if (now - e.sent_time < timeout_reg) break;
                    if (e.retries >= retry_limit_reg) begin
                        expected_results.push_back(mk(KIND_EXHAUST, e.id, e.handle,
                                                      e.retries, 1'b1));
                        void'(table_q.pop_front());
                        return;
                    end
                    void'(table_q.pop_front());
                    e.retries = e.retries + 8'd1;
                    e.sent_time = now;
                    table_q.push_back(e);
                    expected_results.push_back(mk(KIND_RETX, e.id, e.handle, e.retries, 1'b0));
                    left--;
                end
                expected_results.push_back(mk(KIND_WALKEND, 32'd0, 32'd0, 8'd0, 1'b1));
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        tracker_result_t w;
        if (!aresetn) begin
            table_q.delete();
            expected_results.delete();
            timeout_reg <= RESET_TIMEOUT;
            retry_limit_reg <= RESET_RETRY_LIMIT;
            id_counter = FIRST_ID;
            fail_count = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_TIMEOUT) timeout_reg <= cfg_data;
                else retry_limit_reg <= cfg_data[7:0];
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result kind", 32'(m_kind), 32'd0);
                end else begin
                    w = expected_results.pop_front();
                    if (m_kind !== w.kind)
                        report_mismatch("kind", 32'(m_kind), 32'(w.kind));
                    if (m_packet_id !== w.id) report_mismatch("packet_id", m_packet_id, w.id);
                    if (m_owner_handle !== w.handle)
                        report_mismatch("owner_handle", m_owner_handle, w.handle);
                    if (m_retry_count !== w.retries)
                        report_mismatch("retry_count", 32'(m_retry_count), 32'(w.retries));
                    if (m_last !== w.last)
                        report_mismatch("last", 32'(m_last), 32'(w.last));
                end
            end
            if (s_valid && s_ready) predict_item(s_operation, s_handle, s_response_id, s_now_time);
        end
    end

endmodule

/* bench/tb_outstanding_request_retransmit_tracker.sv */
// Top of the retransmit tracker testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_outstanding_request_retransmit_tracker;
    import ortt_pkg::*;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 200000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic        cfg_index = CFG_TIMEOUT;
    logic [31:0] cfg_data = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_operation = OP_SEND;
    logic [31:0] s_handle = 0;
    logic [31:0] s_response_id = 0;
    logic [31:0] s_now_time = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [2:0]  m_kind;
    logic [31:0] m_packet_id;
    logic [31:0] m_owner_handle;
    logic [7:0]  m_retry_count;
    logic        m_last;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    bit          quiet_tail = 0;
    bit          hold_off = 0;
    logic [31:0] clock_now = 0;
    logic [31:0] last_sent_id = 0;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    outstanding_request_retransmit_tracker #(.TABLE_DEPTH(DEPTH)) dut (.*);

    ortt_checker #(.DEPTH(DEPTH)) checker_i (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: bursts of stall, or a long hold-off
    initial begin
        int n;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 0;
                repeat (300) @(negedge aclk);
                m_ready <= 1;
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 6);
                m_ready <= 0;
                repeat (n - 1) @(negedge aclk);
                @(negedge aclk);
                m_ready <= 1;
            end else begin
                m_ready <= 1;
            end
        end
    end

    // valid stays high after a transfer so the next item can follow at once
    task automatic send_item(input logic [1:0] op, input logic [31:0] h,
                             input logic [31:0] rid, input logic [31:0] now);
        int gap;
        @(negedge aclk);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_valid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1;
        s_operation <= op;
        s_handle <= h;
        s_response_id <= rid;
        s_now_time <= now;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(negedge aclk);
        s_valid <= 0;
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 0;
    endtask

    task automatic drain;
        @(negedge aclk);
        s_valid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic random_item;
        int r;
        r = $urandom_range(0, 99);
        clock_now = clock_now + $urandom_range(0, 60);
        if (r < 40) send_item(OP_SEND, $urandom, $urandom, clock_now);
        else if (r < 65) send_item(OP_RESP, $urandom,
                                   last_sent_id - $urandom_range(0, 20), clock_now);
        else if (r < 70) send_item(OP_RESP, $urandom, $urandom, clock_now);
        else if (r < 95) send_item(OP_TICK, $urandom, $urandom, clock_now);
        else send_item(OP_NONE, $urandom, $urandom, clock_now);
        if (r < 40) last_sent_id = last_sent_id + 32'd1;
    endtask

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: tiny timeout, limit 1 then 0
        write_reg(CFG_TIMEOUT, 32'd1);
        write_reg(CFG_RETRY, 32'd1);
        send_item(OP_SEND, 32'hFFFF_FFFF, 0, 32'hFFFF_FFF0);
        send_item(OP_SEND, 32'h0, 0, 32'h0000_0000);
        send_item(OP_RESP, 0, 32'd2, 32'h10);
        send_item(OP_RESP, 0, 32'hFFFF_FFFF, 32'h10);
        send_item(OP_TICK, 0, 0, 32'hFFFF_FFF0);
        send_item(OP_TICK, 0, 0, 32'h20);
        send_item(OP_TICK, 0, 0, 32'h40);
        send_item(OP_TICK, 0, 0, 32'h60);
        send_item(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 17; i++) send_item(OP_SEND, $urandom, 0, 32'h100);
        send_item(OP_TICK, 0, 0, 32'h200);
        drain();
        write_reg(CFG_RETRY, 32'd0);
        send_item(OP_TICK, 0, 0, 32'h300);
        drain();
        write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
        write_reg(CFG_RETRY, 32'd255);
        send_item(OP_TICK, 0, 0, 32'h300);
        for (int i = 0; i < 16; i++) send_item(OP_RESP, 0, 32'd3 + i, 32'h300);
        drain();

        last_sent_id = 32'd18;
        clock_now = 32'h1000;
        write_reg(CFG_TIMEOUT, 32'd100);
        write_reg(CFG_RETRY, 32'd3);
        for (int i = 0; i < 20; i++) random_item();
        // long hold-off so the table and output path back up
        hold_off = 1;
        for (int i = 0; i < 10; i++) random_item();
        hold_off = 0;
        drain();
        write_reg(CFG_TIMEOUT, 32'd30);
        write_reg(CFG_RETRY, 32'd2);
        for (int i = 0; i < 20; i++) random_item();
        drain();
        quiet_tail = 1;
        for (int i = 0; i < 15; i++) random_item();
        drain();

        if (fail_count == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule
